// ===== design/hashed_device_tracking_table_defines.svh =====
// Assertion macros for the device tracking table checker.
`ifndef HASHED_DEVICE_TRACKING_TABLE_DEFINES_SVH
`define HASHED_DEVICE_TRACKING_TABLE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define HDTT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define HDTT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== design/hdtt_pkg.sv =====
// ----------------------------------------------------------------------------
// hdtt_pkg
// Shared types, constants and helpers for the device tracking table.
// ----------------------------------------------------------------------------
package hdtt_pkg;

  localparam int TableDepthDefault = 16;
  localparam logic [31:0] FnvBasis = 32'd2166136261;
  localparam logic [31:0] FnvPrime = 32'd16777619;
  localparam logic [31:0] RateWindowReset = 32'd10000;
  localparam logic [7:0] ThresholdReset = 8'd5;
  localparam logic [7:0] RateMax = 8'd255;

  localparam logic [1:0] OpObserve = 2'd0;
  localparam logic [1:0] OpRecount = 2'd1;
  localparam logic [1:0] OpClear = 2'd2;

  localparam logic CfgRateWindow = 1'b0;
  localparam logic CfgThreshold = 1'b1;

  localparam logic [1:0] KindUnknown = 2'd0;
  localparam logic [1:0] KindPhone = 2'd1;
  localparam logic [1:0] KindComputer = 2'd2;
  localparam logic [1:0] KindWearable = 2'd3;

  // Request passed from the front end to the back end.
  typedef struct packed {
    logic [1:0] op;
    logic [31:0] hash;
    logic [7:0] rssi;
    logic [31:0] now_ms;
    logic [1:0] kind;
  } req_t;

  function automatic logic [1:0] kind_of(input logic has_app, input logic [15:0] app,
                                         input logic has_svc);
    logic [1:0] k;
    k = has_svc ? KindPhone : KindUnknown;
    if (has_app) begin
      if (app >= 16'h0040 && app <= 16'h007F) k = KindPhone;
      else if (app >= 16'h0080 && app <= 16'h00BF) k = KindComputer;
      else if (app >= 16'h00C0 && app <= 16'h00FF) k = KindWearable;
    end
    return k;
  endfunction

endpackage

// ===== design/hashed_device_tracking_table.sv =====
// Observe walks the valid entries up to the match (all of them on a miss), then the
// whole table again on eviction. Recount walks every valid entry; clear and unused
// codes go straight to the finish state.
// The back end takes one request at a time, held by its sequential table walk; the
// front end may hash the next item meanwhile, one multiply per address byte.
// Synchronous active-high rst empties the table and loads register defaults.
// ----------------------------------------------------------------------------
// hashed_device_tracking_table
// FNV-1a keyed device table with oldest-entry replacement.
// ----------------------------------------------------------------------------
module hashed_device_tracking_table #(
  parameter int TableDepth = hdtt_pkg::TableDepthDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        op,
  input  logic [47:0]       mac,
  input  logic signed [7:0] rssi,
  input  logic [31:0]       now_ms,
  input  logic              has_appearance,
  input  logic [15:0]       appearance,
  input  logic              has_service,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [3:0]        entry_index,
  output logic              matched,
  output logic              evicted,
  output logic [31:0]       addr_hash,
  output logic [1:0]        kind,
  output logic [7:0]        rate_count,
  output logic [4:0]        entry_count,
  output logic [4:0]        flagged_count
);

  hdtt_pkg::req_t f_req, q_req;
  logic f_valid, f_ready, q_valid, q_ready;

  hdtt_front u_front (
    .clk, .rst, .in_valid, .in_ready, .op, .mac, .rssi, .now_ms,
    .has_appearance, .appearance, .has_service,
    .req_valid(f_valid), .req_ready(f_ready), .req(f_req)
  );

  hdtt_fifo u_fifo (
    .clk, .rst, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_req),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_req)
  );

  hdtt_back #(.TableDepth(TableDepth)) u_back (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index(cfg_index[0]),
    .cfg_hi_zero(!cfg_index[1]), .cfg_data,
    .req_valid(q_valid), .req_ready(q_ready), .req(q_req),
    .out_valid, .out_ready, .entry_index, .matched, .evicted, .addr_hash,
    .kind, .rate_count, .entry_count, .flagged_count
  );

endmodule

// ===== design/hdtt_front.sv =====
// ----------------------------------------------------------------------------
// hdtt_front
// Accepts items, hashes the address one byte per cycle, classifies the type.
// ----------------------------------------------------------------------------
module hdtt_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          op,
  input  logic [47:0]         mac,
  input  logic signed [7:0]   rssi,
  input  logic [31:0]         now_ms,
  input  logic                has_appearance,
  input  logic [15:0]         appearance,
  input  logic                has_service,
  output logic                req_valid,
  input  logic                req_ready,
  output hdtt_pkg::req_t      req
);

  logic busy;
  logic [2:0] step;
  logic [47:0] mac_sh;
  logic [31:0] h;
  logic [31:0] h_mix;
  logic [31:0] prod;

  assign in_ready = !busy && !req_valid;
  assign h_mix = h ^ {24'd0, mac_sh[47:40]};
  // only the low word of the product is kept
  assign prod = h_mix * hdtt_pkg::FnvPrime;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      req_valid <= 1'b0;
      step <= 3'd0;
    end else begin
      if (req_valid && req_ready) req_valid <= 1'b0;
      if (in_valid && in_ready) begin
        req.op <= op;
        req.rssi <= rssi;
        req.now_ms <= now_ms;
        req.kind <= hdtt_pkg::kind_of(has_appearance, appearance, has_service);
        mac_sh <= mac;
        h <= hdtt_pkg::FnvBasis;
        step <= 3'd0;
        if (op == hdtt_pkg::OpObserve) busy <= 1'b1;
        else begin
          req.hash <= 32'd0;
          req_valid <= 1'b1;
        end
      end else if (busy) begin
        // fold one byte per cycle, high byte first
        h <= prod;
        mac_sh <= {mac_sh[39:0], 8'd0};
        step <= step + 3'd1;
        if (step == 3'd5) begin
          busy <= 1'b0;
          req.hash <= prod;
          req_valid <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== design/hdtt_fifo.sv =====
// ----------------------------------------------------------------------------
// hdtt_fifo
// Two-entry request queue between the front and back ends.
// ----------------------------------------------------------------------------
module hdtt_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  hdtt_pkg::req_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output hdtt_pkg::req_t rd_data
);

  hdtt_pkg::req_t slots [2];
  logic wp, rp;
  logic [1:0] cnt;

  assign wr_ready = cnt != 2'd2;
  assign rd_valid = cnt != 2'd0;
  assign rd_data = slots[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) begin
        slots[wp] <= wr_data;
        wp <= ~wp;
      end
      if (rd_valid && rd_ready) rp <= ~rp;
      cnt <= cnt + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
  end

endmodule

// ===== design/hdtt_back.sv =====
// ----------------------------------------------------------------------------
// hdtt_back
// Walks the table one entry per cycle to search, pick the oldest or recount.
// ----------------------------------------------------------------------------
module hdtt_back #(
  parameter int TableDepth = hdtt_pkg::TableDepthDefault
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_index,
  input  logic           cfg_hi_zero,
  input  logic [31:0]    cfg_data,
  input  logic           req_valid,
  output logic           req_ready,
  input  hdtt_pkg::req_t req,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [3:0]     entry_index,
  output logic           matched,
  output logic           evicted,
  output logic [31:0]    addr_hash,
  output logic [1:0]     kind,
  output logic [7:0]     rate_count,
  output logic [4:0]     entry_count,
  output logic [4:0]     flagged_count
);

  localparam int IW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int CW = $clog2(TableDepth + 1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SEARCH = 5'b00010,
    S_OLDEST = 5'b00100,
    S_COUNT  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state;
  logic [31:0] rate_window;
  logic [7:0] threshold;
  logic [31:0] tab_hash [TableDepth];
  logic [7:0] tab_rssi [TableDepth];
  logic [31:0] tab_seen [TableDepth];
  logic [7:0] tab_rate [TableDepth];
  logic [1:0] tab_kind [TableDepth];
  logic [TableDepth-1:0] tab_flag;
  logic [CW-1:0] valid_entries, flagged_total;
  hdtt_pkg::req_t cur;
  logic [CW-1:0] scan;
  logic [IW-1:0] sel;
  logic [31:0] oldest;
  logic hit;
  logic [31:0] delta;
  logic [IW-1:0] si;

  assign cfg_ready = 1'b1;
  assign req_ready = (state == S_IDLE) && !out_valid;
  assign si = scan[IW-1:0];
  assign delta = cur.now_ms - tab_seen[sel];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      valid_entries <= '0;
      flagged_total <= '0;
      tab_flag <= '0;
      rate_window <= hdtt_pkg::RateWindowReset;
      threshold <= hdtt_pkg::ThresholdReset;
    end else begin
      if (cfg_valid && cfg_hi_zero) begin
        if (cfg_index == hdtt_pkg::CfgRateWindow) rate_window <= cfg_data;
        else threshold <= cfg_data[7:0];
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req_valid && req_ready) begin
            cur <= req;
            scan <= '0;
            hit <= 1'b0;
            sel <= '0;
            if (req.op == hdtt_pkg::OpObserve) state <= S_SEARCH;
            else if (req.op == hdtt_pkg::OpRecount) begin
              flagged_total <= '0;
              state <= S_COUNT;
            end else begin
              if (req.op == hdtt_pkg::OpClear) begin
                valid_entries <= '0;
                flagged_total <= '0;
              end
              state <= S_FINISH;
            end
          end
        end
        S_SEARCH: begin
          if (scan >= valid_entries) begin
            if (valid_entries < CW'(TableDepth)) begin
              sel <= IW'(valid_entries);
              valid_entries <= valid_entries + CW'(1);
              state <= S_FINISH;
            end else begin
              oldest <= tab_seen[0];
              sel <= '0;
              scan <= CW'(1);
              state <= S_OLDEST;
            end
          end else if (tab_hash[si] == cur.hash) begin
            sel <= si;
            hit <= 1'b1;
            state <= S_FINISH;
          end else scan <= scan + CW'(1);
        end
        S_OLDEST: begin
          if (scan >= CW'(TableDepth)) state <= S_FINISH;
          else begin
            if (tab_seen[si] < oldest) begin
              oldest <= tab_seen[si];
              sel <= si;
            end
            scan <= scan + CW'(1);
          end
        end
        S_COUNT: begin
          if (scan >= valid_entries) state <= S_FINISH;
          else begin
            if (tab_rate[si] >= threshold) begin
              tab_flag[si] <= 1'b1;
              flagged_total <= flagged_total + CW'(1);
            end
            scan <= scan + CW'(1);
          end
        end
        S_FINISH: begin
          entry_index <= '0;
          matched <= 1'b0;
          evicted <= 1'b0;
          addr_hash <= '0;
          kind <= '0;
          rate_count <= '0;
          entry_count <= 5'(valid_entries);
          flagged_count <= 5'(flagged_total);
          if (cur.op == hdtt_pkg::OpObserve) begin
            entry_index <= 4'(sel);
            addr_hash <= cur.hash;
            tab_rssi[sel] <= cur.rssi;
            tab_seen[sel] <= cur.now_ms;
            if (hit) begin
              matched <= 1'b1;
              kind <= tab_kind[sel];
              if (delta < rate_window && tab_rate[sel] != hdtt_pkg::RateMax) begin
                tab_rate[sel] <= tab_rate[sel] + 8'd1;
                rate_count <= tab_rate[sel] + 8'd1;
              end else rate_count <= tab_rate[sel];
            end else begin
              // only the oldest-entry walk leaves scan at the table depth
              evicted <= (scan == CW'(TableDepth)) && (valid_entries == CW'(TableDepth));
              tab_hash[sel] <= cur.hash;
              tab_rate[sel] <= '0;
              tab_flag[sel] <= 1'b0;
              tab_kind[sel] <= cur.kind;
              kind <= cur.kind;
            end
          end
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/hdtt_checker.sv =====
// ----------------------------------------------------------------------------
// hdtt_checker
// Port-level checks for the device tracking table.
// ----------------------------------------------------------------------------
`include "hashed_device_tracking_table_defines.svh"
module hdtt_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       matched,
  input logic       evicted,
  input logic [4:0] entry_count,
  input logic [4:0] flagged_count,
  input logic [3:0] entry_index
);

  `HDTT_ASSERT_IMPL(a_hit_no_evict, clk, rst, out_valid, !(matched && evicted), "hit and evict")
  `HDTT_ASSERT_IMPL(a_flag_le_count, clk, rst, out_valid, flagged_count <= entry_count, "flag count")
  `HDTT_ASSERT_IMPL(a_idx_range, clk, rst, out_valid && matched, 5'(entry_index) < entry_count, "index")
  `HDTT_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(entry_count), "hold")

endmodule

bind hashed_device_tracking_table hdtt_checker u_checker (
  .clk, .rst, .out_valid, .out_ready, .matched, .evicted,
  .entry_count, .flagged_count, .entry_index
);

// ===== dv/hdtt_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdtt_tb_pkg
// Request and result records plus the device table scoreboard, which mirrors
// the hashed table and queues the expected result of every accepted request.
// ----------------------------------------------------------------------------
package hdtt_tb_pkg;
  import hdtt_pkg::*;

  localparam logic [1:0] OpUnused     = 2'd3;
  localparam logic [1:0] RegWindow    = {1'b0, CfgRateWindow};
  localparam logic [1:0] RegThreshold = {1'b0, CfgThreshold};
  localparam logic [1:0] RegSpare     = 2'd3;
  localparam int         Slots        = 16;

  typedef struct {
    logic [1:0]        op;
    logic [47:0]       mac;
    logic signed [7:0] rssi;
    logic [31:0]       now_ms;
    logic              has_appearance;
    logic [15:0]       appearance;
    logic              has_service;
  } dev_req_t;

  typedef struct {
    logic [3:0]  entry_index;
    logic        matched;
    logic        evicted;
    logic [31:0] addr_hash;
    logic [1:0]  kind;
    logic [7:0]  rate_count;
    logic [4:0]  entry_count;
    logic [4:0]  flagged_count;
  } dev_result_t;

  class device_table_scoreboard;
    logic [31:0] slot_hash[Slots];
    logic [7:0]  slot_rssi[Slots];
    logic [31:0] slot_seen[Slots];
    logic [7:0]  slot_rate[Slots];
    logic        slot_flag[Slots];
    logic [1:0]  slot_kind[Slots];
    int unsigned live_slots;
    int unsigned scanners;
    logic [31:0] window_ms;
    logic [7:0]  threshold;
    dev_result_t expected_q[$];
    int unsigned errors;
    int unsigned results_checked;

    function new();
      window_ms = RateWindowReset;
      threshold = ThresholdReset;
      live_slots = 0;
      scanners = 0;
      errors = 0;
      results_checked = 0;
      foreach (slot_flag[i]) slot_flag[i] = 1'b0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] data);
      if (idx == RegWindow) window_ms = data;
      else if (idx == RegThreshold) threshold = data[7:0];
    endfunction

    function logic [31:0] addr_fnv(logic [47:0] mac);
      logic [31:0] h;
      h = FnvBasis;
      for (int b = 5; b >= 0; b--) begin
        h = h ^ {24'd0, mac[8*b +: 8]};
        h = h * FnvPrime;
      end
      return h;
    endfunction

    function logic [1:0] classify(dev_req_t r);
      if (r.has_appearance) begin
        if (r.appearance >= 16'h0040 && r.appearance <= 16'h007F) return KindPhone;
        if (r.appearance >= 16'h0080 && r.appearance <= 16'h00BF) return KindComputer;
        if (r.appearance >= 16'h00C0 && r.appearance <= 16'h00FF) return KindWearable;
      end
      return r.has_service ? KindPhone : KindUnknown;
    endfunction

    function void note_request(dev_req_t r);
      dev_result_t e;
      int unsigned slot;
      bit found;
      logic [31:0] oldest;
      e = '{default: '0};
      slot = 0;
      found = 0;
      if (r.op == OpObserve) begin
        e.addr_hash = addr_fnv(r.mac);
        for (int i = 0; i < live_slots; i++) begin
          if (!found && slot_hash[i] == e.addr_hash) begin
            slot = i;
            found = 1;
          end
        end
        if (found) begin
          e.matched = 1'b1;
          slot_rssi[slot] = r.rssi;
          if ((r.now_ms - slot_seen[slot]) < window_ms && slot_rate[slot] != RateMax)
            slot_rate[slot]++;
          slot_seen[slot] = r.now_ms;
        end else begin
          if (live_slots < Slots) begin
            slot = live_slots;
            live_slots++;
          end else begin
            // replace smallest sighting time, lowest index wins ties
            e.evicted = 1'b1;
            oldest = slot_seen[0];
            for (int i = 1; i < Slots; i++) begin
              if (slot_seen[i] < oldest) begin
                oldest = slot_seen[i];
                slot = i;
              end
            end
          end
          slot_hash[slot] = e.addr_hash;
          slot_rssi[slot] = r.rssi;
          slot_seen[slot] = r.now_ms;
          slot_rate[slot] = 8'd0;
          slot_flag[slot] = 1'b0;
          slot_kind[slot] = classify(r);
        end
        e.entry_index = slot[3:0];
        e.kind = slot_kind[slot];
        e.rate_count = slot_rate[slot];
      end else if (r.op == OpRecount) begin
        scanners = 0;
        for (int i = 0; i < live_slots; i++) begin
          if (slot_rate[i] >= threshold) begin
            slot_flag[i] = 1'b1;
            scanners++;
          end
        end
      end else if (r.op == OpClear) begin
        live_slots = 0;
        scanners = 0;
      end
      e.entry_count = live_slots[4:0];
      e.flagged_count = scanners[4:0];
      expected_q.push_back(e);
    endfunction

    task report(string msg);
      $display("MISMATCH result %0d: %s", results_checked, msg);
      errors++;
    endtask

    task check_result(dev_result_t got);
      dev_result_t e;
      results_checked++;
      if (expected_q.size() == 0) begin
        report("result with no request pending");
        return;
      end
      e = expected_q.pop_front();
      if (got.entry_index !== e.entry_index)
        report($sformatf("entry_index %0d want %0d", got.entry_index, e.entry_index));
      if (got.matched !== e.matched)
        report($sformatf("matched %0b want %0b", got.matched, e.matched));
      if (got.evicted !== e.evicted)
        report($sformatf("evicted %0b want %0b", got.evicted, e.evicted));
      if (got.addr_hash !== e.addr_hash)
        report($sformatf("addr_hash %h want %h", got.addr_hash, e.addr_hash));
      if (got.kind !== e.kind)
        report($sformatf("kind %0d want %0d", got.kind, e.kind));
      if (got.rate_count !== e.rate_count)
        report($sformatf("rate_count %0d want %0d", got.rate_count, e.rate_count));
      if (got.entry_count !== e.entry_count)
        report($sformatf("entry_count %0d want %0d", got.entry_count, e.entry_count));
      if (got.flagged_count !== e.flagged_count)
        report($sformatf("flagged_count %0d want %0d", got.flagged_count, e.flagged_count));
    endtask
  endclass

endpackage

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives observe, recount and clear requests into the device tracking table
// under several register settings and idle patterns, checking every result.
// ----------------------------------------------------------------------------
module tb_top;
  import hdtt_pkg::*;
  import hdtt_tb_pkg::*;

  localparam int StallLimit = 5000;
  localparam int SettleCycles = 64;
  localparam int HoldCycles = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] op = '0;
  logic [47:0] mac = '0;
  logic signed [7:0] rssi = '0;
  logic [31:0] now_ms = '0;
  logic has_appearance = 1'b0;
  logic [15:0] appearance = '0;
  logic has_service = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [3:0] entry_index;
  logic matched, evicted;
  logic [31:0] addr_hash;
  logic [1:0] kind;
  logic [7:0] rate_count;
  logic [4:0] entry_count, flagged_count;

  device_table_scoreboard table_sb;
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  bit hold_request = 0;
  int unsigned requests_sent = 0;
  int unsigned quiet_cycles = 0;
  logic [31:0] clock_ms = '0;
  logic [47:0] mac_pool[40];

  hashed_device_tracking_table i_dut (.*);

  always #2 clk = ~clk;

  // receiver: check accepted results, then pick next ready
  always @(posedge clk) begin : receiver
    int unsigned hold_left;
    dev_result_t got;
    if (!rst && out_valid && out_ready) begin
      got = '{entry_index, matched, evicted, addr_hash, kind, rate_count,
              entry_count, flagged_count};
      table_sb.check_result(got);
    end
    if (hold_request) begin
      hold_request = 0;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("timeout: no handshake for %0d cycles", StallLimit);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    table_sb.write_reg(idx, data);
  endtask

  task send_request(dev_req_t r);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    op <= r.op;
    mac <= r.mac;
    rssi <= r.rssi;
    now_ms <= r.now_ms;
    has_appearance <= r.has_appearance;
    appearance <= r.appearance;
    has_service <= r.has_service;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    table_sb.note_request(r);
    requests_sent++;
  endtask

  task observe(logic [47:0] a, logic signed [7:0] s, logic [31:0] t, logic ha,
               logic [15:0] app, logic hs);
    send_request('{OpObserve, a, s, t, ha, app, hs});
  endtask

  task send_op(logic [1:0] code);
    send_request('{code, 48'd0, 8'sd0, clock_ms, 1'b0, 16'd0, 1'b0});
  endtask

  // hold the sender until every pending result is back, then let it settle
  task drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (table_sb.expected_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task random_request(int unsigned pool_size);
    dev_req_t r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    r.op = (pick < 86) ? OpObserve : (pick < 92) ? OpRecount : (pick < 97) ? OpClear : OpUnused;
    pick = $urandom_range(0, 99);
    if (pick < 4) clock_ms = $urandom;
    else if (pick < 7) clock_ms = 32'hFFFF_FF00 + $urandom_range(0, 255);
    else clock_ms = clock_ms + $urandom_range(0, 300);
    r.now_ms = clock_ms;
    r.mac = ($urandom_range(0, 99) < 3) ? {16'($urandom), 32'($urandom)}
                                        : mac_pool[$urandom_range(0, pool_size - 1)];
    r.rssi = $urandom;
    r.has_appearance = $urandom;
    r.appearance = ($urandom_range(0, 99) < 70) ? 16'($urandom_range(0, 16'h1FF)) : 16'($urandom);
    r.has_service = $urandom;
    send_request(r);
  endtask

  task run_phase(logic [31:0] window, logic [7:0] thresh, int unsigned idle_pct,
                 int unsigned stall_pct, int unsigned pool_size, int unsigned count,
                 bit long_hold);
    write_reg(RegWindow, window);
    write_reg(RegThreshold, thresh);
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    foreach (mac_pool[i]) mac_pool[i] = {16'($urandom), 32'($urandom)};
    for (int n = 0; n < count; n++) begin
      if (long_hold && n == count / 2) hold_request = 1;
      random_request(pool_size);
    end
    drain();
  endtask

  initial begin : stimulus
    table_sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, every kind range, window edge, ops, eviction tie
    observe(48'd0, 8'sd0, 32'd0, 1'b1, 16'h0040, 1'b0);
    observe(48'hFFFF_FFFF_FFFF, -8'sd128, 32'hFFFF_FFFF, 1'b1, 16'h00FF, 1'b1);
    observe(48'd0, 8'sd127, 32'd9999, 1'b0, 16'd0, 1'b0);
    observe(48'd0, 8'sd1, 32'd19999, 1'b0, 16'd0, 1'b0);
    observe(48'h0000_0000_0A0A, 8'sd5, 32'd20, 1'b1, 16'h0080, 1'b0);
    observe(48'h0000_0000_0B0B, 8'sd6, 32'd21, 1'b1, 16'h00C0, 1'b0);
    observe(48'h0000_0000_0C0C, 8'sd7, 32'd22, 1'b0, 16'hFFFF, 1'b1);
    observe(48'h0000_0000_0D0D, 8'sd8, 32'd23, 1'b1, 16'h003F, 1'b0);
    observe(48'h0000_0000_0E0E, 8'sd9, 32'd24, 1'b1, 16'hFFFF, 1'b1);
    send_op(OpRecount);
    send_op(OpUnused);
    send_op(OpClear);
    for (int i = 0; i < 16; i++)
      observe(48'h1234_0000_0000 + i, 8'sd0, 32'd100, 1'b0, 16'd0, 1'b0);
    observe(48'h5678_0000_0000, 8'sd0, 32'd101, 1'b0, 16'd0, 1'b1);
    drain();
    write_reg(RegSpare, $urandom);

    run_phase(32'd10000, 8'd5, 0, 0, 24, 400, 1'b0);
    run_phase(32'hFFFF_FFFF, 8'd255, 49, 0, 2, 400, 1'b0);
    run_phase(32'd0, 8'd0, 0, 49, 24, 350, 1'b0);
    run_phase(32'd500, 8'd3, 10, 10, 40, 400, 1'b1);

    $display("covered %0d requests and %0d results over four register settings",
             requests_sent, table_sb.results_checked);
    $display("with hits, appends, evictions, recounts, clears and wrapped timestamps");
    if (table_sb.errors == 0 && table_sb.expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
